>>> sv/mbc_pkg.sv
// Shared types, constants and fixed-point helpers for the multichannel biquad cascade.
// Depends on nothing; mbc_seq, mbc_mac and the top level in sv/ import it.
`timescale 1ns / 1ps
`default_nettype none
package mbc_pkg;

	localparam int CHANNELS     = 8;
	localparam int MAX_SECTIONS = 2;

	// Payload widths
	localparam int CHAN_W   = 3;
	localparam int S_W      = 24;  // sample width
	localparam int COEF_W   = 20;  // Q3.17
	localparam int W_W      = 40;  // delay word, 8 fraction bits
	localparam int HALF_W   = 20;  // low half of a delay word fed to the multiplier
	localparam int PROD_W   = COEF_W + HALF_W + 1;
	localparam int ACC_W    = 62;
	localparam int NSEC_W   = 2;
	localparam int SEC_W    = 1;
	localparam int NUM_W    = 60;
	localparam int DEN_W    = 40;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 60;
	localparam int NUM_COEF_SETS = 2;

	localparam int IN_FRAC    = 8;   // sample enters shifted left by this
	localparam int FRAC_SHIFT = 17;  // coefficient fraction bits

	localparam int DEPTH  = CHANNELS * MAX_SECTIONS;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int ENTRY_W = 2 * W_W;  // {w2, w1}

	localparam int STEP_W = 3;
	localparam logic [STEP_W-1:0] FB_LAST = 3'd4;  // four partial products, then drain
	localparam logic [STEP_W-1:0] FF_LAST = 3'd6;  // six partial products, then drain

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SEC0_NUM = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SEC0_DEN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SEC1_NUM = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SEC1_DEN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NSEC     = 3'd4;

	localparam logic signed [W_W-1:0] W_MAX = {1'b0, {(W_W-1){1'b1}}};
	localparam logic signed [W_W-1:0] W_MIN = {1'b1, {(W_W-1){1'b0}}};
	localparam logic signed [S_W-1:0] S_MAX = {1'b0, {(S_W-1){1'b1}}};
	localparam logic signed [S_W-1:0] S_MIN = {1'b1, {(S_W-1){1'b0}}};
	localparam logic signed [ACC_W-1:0] RND17 = ACC_W'(65536);
	localparam logic signed [W_W:0] Y_RND = (W_W+1)'(128);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_LOAD,
		ST_FB,
		ST_WN,
		ST_FF,
		ST_VOUT,
		ST_OUT
	} seq_state_t;

	typedef struct packed {
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} coef_set_t;

	typedef struct packed {
		logic                     load;
		logic signed [ACC_W-1:0]  load_val;
		logic                     issue;
		logic                     sub;
		logic                     hi;
		logic signed [COEF_W-1:0] coef;
		logic signed [W_W-1:0]    word;
	} mac_cmd_t;

	typedef struct packed {
		logic                rd_en;
		logic                wr_en;
		logic [ADDR_W-1:0]   addr;
		logic [ENTRY_W-1:0]  wr_data;
	} ram_req_t;

	typedef struct packed {
		logic signed [W_W-1:0] val;
		logic                  clip;
	} w_rc_t;

	typedef struct packed {
		logic signed [S_W-1:0] val;
		logic                  clip;
	} s_rc_t;

	// Round a 25-fraction-bit sum to 8 fraction bits (halves up), saturate to 40 bits.
	function automatic w_rc_t round_clip_w(input logic signed [ACC_W-1:0] acc);
		logic signed [ACC_W-1:0] s;
		w_rc_t r;
		s = (acc + RND17) >>> FRAC_SHIFT;
		r.clip = (s[ACC_W-1:W_W-1] != {(ACC_W-W_W+1){s[ACC_W-1]}});
		r.val  = r.clip ? (s[ACC_W-1] ? W_MIN : W_MAX) : s[W_W-1:0];
		return r;
	endfunction

	// Round an 8-fraction-bit word to an integer, saturate to 24 bits.
	function automatic s_rc_t round_clip_s(input logic signed [W_W-1:0] v);
		logic signed [W_W:0] t;
		s_rc_t r;
		t = ($signed({v[W_W-1], v}) + Y_RND) >>> IN_FRAC;
		r.clip = (t[W_W:S_W-1] != {(W_W-S_W+2){t[W_W]}});
		r.val  = r.clip ? (t[W_W] ? S_MIN : S_MAX) : t[S_W-1:0];
		return r;
	endfunction

endpackage
`default_nettype wire

>>> sv/mbc_state_ram.sv
// Delay-word memory: one entry {w2, w1} per channel and section, registered read.
// Per-entry valid bits make never-written entries read as zero after reset.
`timescale 1ns / 1ps
`default_nettype none
module mbc_state_ram #(
	parameter int WIDTH = 80,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [WIDTH-1:0] rd_data_q;
	logic             rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_valid_q ? rd_data_q : '0;

endmodule
`default_nettype wire

>>> sv/mbc_mac.sv
// Shared multiply-accumulate: a 20 x 21 signed multiplier fed half a delay word per cycle,
// product registered, then added into a 62-bit accumulator. Uses mbc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mbc_mac
	import mbc_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire mac_cmd_t         cmd,
	output logic signed [ACC_W-1:0] acc
);

	logic signed [COEF_W:0]   part;
	logic signed [PROD_W-1:0] prod;
	logic signed [PROD_W-1:0] prod_s1;
	logic                     hi_s1;
	logic                     sub_s1;
	logic                     vld_s1;
	logic signed [ACC_W-1:0]  ext;
	logic signed [ACC_W-1:0]  addend;
	logic signed [ACC_W-1:0]  acc_q;

	// High half is signed, low half is a plain magnitude.
	always_comb begin
		part = cmd.hi ? {cmd.word[W_W-1], cmd.word[W_W-1:HALF_W]}
			: {1'b0, cmd.word[HALF_W-1:0]};
	end

	assign prod = cmd.coef * part;

	always_ff @(posedge clk) begin
		prod_s1 <= prod;
		hi_s1   <= cmd.hi;
		sub_s1  <= cmd.sub;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= cmd.issue;
		end
	end

	always_comb begin
		ext    = {{(ACC_W-PROD_W){prod_s1[PROD_W-1]}}, prod_s1};
		addend = hi_s1 ? (ext <<< HALF_W) : ext;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			acc_q <= cmd.load_val;
		end else if (vld_s1) begin
			acc_q <= sub_s1 ? (acc_q - addend) : (acc_q + addend);
		end
	end

	assign acc = acc_q;

`ifndef NO_ASSERTIONS
	// A load must never overwrite a product still on its way into the accumulator.
	a_load_drained: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !vld_s1)
		else $error("mbc_mac: accumulator load while a product is pending");
`endif

endmodule
`default_nettype wire

>>> sv/mbc_seq.sv
// Sequencer and datapath registers: reads a channel's delay words, steps the shared MAC
// through the feedback and feedforward sums, writes the words back. Uses mbc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mbc_seq
	import mbc_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic [CHAN_W-1:0]        chan,
	input  wire logic signed [S_W-1:0]    sample_in,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic [CHAN_W-1:0]             chan_out,
	output logic signed [S_W-1:0]         sample_out,
	output logic                          saturated,
	input  wire coef_set_t                coefs [NUM_COEF_SETS],
	input  wire logic [NSEC_W-1:0]        nsec_cfg,
	output mac_cmd_t                      mac_cmd,
	input  wire logic signed [ACC_W-1:0]  acc,
	output ram_req_t                      ram_req,
	input  wire logic [ENTRY_W-1:0]       ram_rd_data
);

	seq_state_t state_q, state_d;

	logic [STEP_W-1:0]      step_q;
	logic [SEC_W-1:0]       sec_q;
	logic [NSEC_W-1:0]      nsec_q;
	logic [NSEC_W-1:0]      nsec_in;
	logic [CHAN_W-1:0]      chan_q;
	logic signed [W_W-1:0]  v_q;
	logic signed [W_W-1:0]  w1_q;
	logic signed [W_W-1:0]  w2_q;
	logic signed [W_W-1:0]  wn_q;
	logic                   sat_q;
	logic                   out_valid_q;
	logic [CHAN_W-1:0]      chan_out_q;
	logic signed [S_W-1:0]  sample_out_q;
	logic                   saturated_q;

	logic       accept;
	logic       chan_ok;
	logic       more_sec;
	logic       out_load;
	coef_set_t  cs;
	w_rc_t      rc_w;
	s_rc_t      rc_s;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign chan_ok  = (32'(chan) < 32'(CHANNELS));
	assign nsec_in  = (32'(nsec_cfg) > 32'(MAX_SECTIONS)) ? NSEC_W'(MAX_SECTIONS) : nsec_cfg;
	assign more_sec = ((NSEC_W'(sec_q) + NSEC_W'(1)) < nsec_q);
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || !out_stall);
	assign cs       = coefs[sec_q];
	assign rc_w     = round_clip_w(acc);
	assign rc_s     = round_clip_s(v_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d          = state_q;
		mac_cmd          = '0;
		ram_req          = '0;
		ram_req.addr     = ADDR_W'(32'(chan_q) * MAX_SECTIONS + 32'(sec_q));
		ram_req.wr_data  = {w1_q, wn_q};
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = (chan_ok && nsec_in != '0) ? ST_READ : ST_OUT;
				end
			end
			ST_READ: begin
				ram_req.rd_en = 1'b1;
				state_d       = ST_LOAD;
			end
			ST_LOAD: begin
				mac_cmd.load     = 1'b1;
				mac_cmd.load_val = {{(ACC_W-W_W-FRAC_SHIFT){v_q[W_W-1]}}, v_q,
					{FRAC_SHIFT{1'b0}}};
				state_d          = ST_FB;
			end
			ST_FB: begin
				// subtract a1*w1 then a2*w2, half a word per step
				mac_cmd.issue = (step_q < FB_LAST);
				mac_cmd.sub   = 1'b1;
				mac_cmd.hi    = step_q[0];
				if (step_q[1]) begin
					mac_cmd.coef = cs.den[2*COEF_W-1:COEF_W];
					mac_cmd.word = w2_q;
				end else begin
					mac_cmd.coef = cs.den[COEF_W-1:0];
					mac_cmd.word = w1_q;
				end
				if (step_q == FB_LAST) begin
					state_d = ST_WN;
				end
			end
			ST_WN: begin
				mac_cmd.load = 1'b1;
				state_d      = ST_FF;
			end
			ST_FF: begin
				mac_cmd.issue = (step_q < FF_LAST);
				mac_cmd.hi    = step_q[0];
				case (step_q[STEP_W-1:1])
					2'd0: begin
						mac_cmd.coef = cs.num[COEF_W-1:0];
						mac_cmd.word = wn_q;
					end
					2'd1: begin
						mac_cmd.coef = cs.num[2*COEF_W-1:COEF_W];
						mac_cmd.word = w1_q;
					end
					2'd2: begin
						mac_cmd.coef = cs.num[3*COEF_W-1:2*COEF_W];
						mac_cmd.word = w2_q;
					end
					default: begin
						mac_cmd.issue = 1'b0;
					end
				endcase
				if (step_q == FF_LAST) begin
					state_d = ST_VOUT;
				end
			end
			ST_VOUT: begin
				ram_req.wr_en = 1'b1;
				state_d       = more_sec ? ST_READ : ST_OUT;
			end
			ST_OUT: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// step counter only runs inside the two product phases
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if ((state_q == ST_FB || state_q == ST_FF) && state_d == state_q) begin
			step_q <= step_q + STEP_W'(1);
		end else begin
			step_q <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_q  <= '0;
			nsec_q <= '0;
		end else if (accept) begin
			sec_q  <= '0;
			nsec_q <= nsec_in;
		end else if (state_q == ST_VOUT && more_sec) begin
			sec_q <= sec_q + SEC_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			chan_q <= chan;
			v_q    <= {{(W_W-S_W-IN_FRAC){sample_in[S_W-1]}}, sample_in, {IN_FRAC{1'b0}}};
			sat_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					w1_q <= ram_rd_data[W_W-1:0];
					w2_q <= ram_rd_data[ENTRY_W-1:W_W];
				end
				ST_WN: begin
					wn_q  <= rc_w.val;
					sat_q <= sat_q | rc_w.clip;
				end
				ST_VOUT: begin
					v_q   <= rc_w.val;
					sat_q <= sat_q | rc_w.clip;
				end
				default: begin
				end
			endcase
		end
	end

	// output register: holds a finished transaction while downstream stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			chan_out_q   <= chan_q;
			sample_out_q <= rc_s.val;
			saturated_q  <= sat_q | rc_s.clip;
		end
	end

	assign out_valid  = out_valid_q;
	assign chan_out   = chan_out_q;
	assign sample_out = sample_out_q;
	assign saturated  = saturated_q;

`ifndef NO_ASSERTIONS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("mbc_seq: input not held off after a transaction");

	a_result_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_OUT))
		else $error("mbc_seq: result appeared outside the output step");

	a_read_before_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD) |-> $past(ram_req.rd_en))
		else $error("mbc_seq: delay words taken without a read one cycle earlier");
`endif

endmodule
`default_nettype wire

>>> sv/multichannel_biquad_cascade_unit.sv
// Top level of the multichannel biquad cascade: configuration registers and the wiring of
// sequencer, shared MAC and delay-word memory. Uses mbc_pkg, mbc_seq, mbc_mac, mbc_state_ram.
//
//   channel   direction  handshake             payload
//   input     in         in_valid / in_stall    chan, sample_in
//   output    out        out_valid / out_stall  chan_out, sample_out, saturated
//   config    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One transaction at a time; the next is taken only once the previous one has passed
// every active section and reached the output step. Each section costs
// a memory read, ten 20 x 21 partial products on the single shared multiplier, two
// rounding steps and a write-back. A finished result waits in the output register while
// out_stall is high; the next input is held off until that result has a free register.
// Reset clears the configuration and the delay-word valid bits at once; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module multichannel_biquad_cascade_unit
	import mbc_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire logic [CHAN_W-1:0]       chan,
	input  wire logic signed [S_W-1:0]   sample_in,
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output logic [CHAN_W-1:0]            chan_out,
	output logic signed [S_W-1:0]        sample_out,
	output logic                         saturated,
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [CFG_DATA_W-1:0]   cfg_data
);

	logic [NUM_W-1:0]  sec0_num_q;
	logic [DEN_W-1:0]  sec0_den_q;
	logic [NUM_W-1:0]  sec1_num_q;
	logic [DEN_W-1:0]  sec1_den_q;
	logic [NSEC_W-1:0] nsec_q;

	coef_set_t               coefs [NUM_COEF_SETS];
	mac_cmd_t                mac_cmd;
	logic signed [ACC_W-1:0] acc;
	ram_req_t                ram_req;
	logic [ENTRY_W-1:0]      ram_rd_data;

	assign cfg_ready = 1'b1;

	// drop writes to unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec0_num_q <= '0;
			sec0_den_q <= '0;
			sec1_num_q <= '0;
			sec1_den_q <= '0;
			nsec_q     <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SEC0_NUM: sec0_num_q <= cfg_data[NUM_W-1:0];
				REG_SEC0_DEN: sec0_den_q <= cfg_data[DEN_W-1:0];
				REG_SEC1_NUM: sec1_num_q <= cfg_data[NUM_W-1:0];
				REG_SEC1_DEN: sec1_den_q <= cfg_data[DEN_W-1:0];
				REG_NSEC:     nsec_q     <= cfg_data[NSEC_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		coefs[0] = '{num: sec0_num_q, den: sec0_den_q};
		coefs[1] = '{num: sec1_num_q, den: sec1_den_q};
	end

	mbc_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.chan        (chan),
		.sample_in   (sample_in),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.chan_out    (chan_out),
		.sample_out  (sample_out),
		.saturated   (saturated),
		.coefs       (coefs),
		.nsec_cfg    (nsec_q),
		.mac_cmd     (mac_cmd),
		.acc         (acc),
		.ram_req     (ram_req),
		.ram_rd_data (ram_rd_data)
	);

	mbc_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (mac_cmd),
		.acc    (acc)
	);

	mbc_state_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (DEPTH),
		.AW    (ADDR_W)
	) u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (ram_req.rd_en),
		.rd_addr (ram_req.addr),
		.rd_data (ram_rd_data),
		.wr_en   (ram_req.wr_en),
		.wr_addr (ram_req.addr),
		.wr_data (ram_req.wr_data)
	);

endmodule
`default_nettype wire

>>> sim/tb.sv
// Self-checking bench for multichannel_biquad_cascade_unit: a directed stimulus table,
// then randomized register settings and samples, scored against a local fixed-point filter
// or, where a table row gives one, its expected result. Depends on mbc_pkg and the RTL under sv/.
`timescale 1ns / 1ps
module tb;
	import mbc_pkg::*;

	localparam int PHASES      = 11;
	localparam int PHASE_ITEMS = 150;
	localparam int LIMIT       = 600000;
	localparam int TAIL        = 40;
	localparam int GAP_PCT     = 19;

	localparam logic [COEF_W-1:0] COEF_ONE    = 20'h20000;  // 1.0 in Q3.17
	localparam logic [COEF_W-1:0] COEF_TOP    = 20'h7FFFF;
	localparam logic [COEF_W-1:0] COEF_BOTTOM = 20'h80000;
	localparam logic [COEF_W-1:0] COEF_LSB_N  = 20'hFFFFF;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = REG_NSEC + CFG_IDX_W'(1);

	localparam logic signed [63:0] WORD_HI = (64'sd1 <<< (W_W - 1)) - 64'sd1;
	localparam logic signed [63:0] WORD_LO = -(64'sd1 <<< (W_W - 1));
	localparam logic signed [63:0] SMP_HI  = (64'sd1 <<< (S_W - 1)) - 64'sd1;
	localparam logic signed [63:0] SMP_LO  = -(64'sd1 <<< (S_W - 1));

	typedef struct packed {
		logic [CHAN_W-1:0]     chan;
		logic signed [S_W-1:0] sample;
		logic                  sat;
	} filt_t;

	typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

	typedef struct packed {
		row_kind_t              kind;
		logic [CFG_IDX_W-1:0]   idx;
		logic [CFG_DATA_W-1:0]  data;
		logic [CHAN_W-1:0]      chan;
		logic signed [S_W-1:0]  x;
		logic                   known;
		logic signed [S_W-1:0]  y;
		logic                   y_sat;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [CHAN_W-1:0] chan = '0;
	logic signed [S_W-1:0] sample_in = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [CHAN_W-1:0] chan_out;
	logic signed [S_W-1:0] sample_out;
	logic saturated;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// local copy of the filter: coefficients, section count, delay words
	logic [NUM_W-1:0] num_cfg [NUM_COEF_SETS];
	logic [DEN_W-1:0] den_cfg [NUM_COEF_SETS];
	logic [NSEC_W-1:0] nsec_cfg;
	logic signed [W_W-1:0] tap1 [DEPTH];
	logic signed [W_W-1:0] tap2 [DEPTH];
	bit clip_seen;

	filt_t filtered_q [$];
	row_t plan [$];
	bit no_gaps = 1'b0;
	int errors = 0;
	int samples_sent = 0;
	int writes_done = 0;
	int results_seen = 0;
	int cycle_cnt = 0;

	multichannel_biquad_cascade_unit u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.chan       (chan),
		.sample_in  (sample_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.chan_out   (chan_out),
		.sample_out (sample_out),
		.saturated  (saturated),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	always @(negedge clk) begin
		out_stall <= !no_gaps && ($urandom_range(0, 99) < GAP_PCT);
	end

	function automatic logic signed [63:0] coef_at(input logic [NUM_W-1:0] word, input int pos);
		logic signed [COEF_W-1:0] c;
		logic signed [63:0] r;
		c = word[pos +: COEF_W];
		r = c;
		return r;
	endfunction

	// round 25 fraction bits down to 8, halves up, then clamp to a delay word
	function automatic logic signed [63:0] to_word(input logic signed [63:0] acc);
		logic signed [63:0] r;
		r = (acc + 64'sd65536) >>> FRAC_SHIFT;
		if (r > WORD_HI) begin
			clip_seen = 1'b1;
			r = WORD_HI;
		end else if (r < WORD_LO) begin
			clip_seen = 1'b1;
			r = WORD_LO;
		end
		return r;
	endfunction

	function automatic filt_t biquad_predict(input logic [CHAN_W-1:0] ch,
			input logic signed [S_W-1:0] x);
		logic signed [63:0] v, w1, w2, acc, wn;
		int n, idx;
		filt_t r;
		clip_seen = 1'b0;
		r.chan = ch;
		n = (nsec_cfg > MAX_SECTIONS) ? MAX_SECTIONS : nsec_cfg;
		if (n == 0 || ch >= CHANNELS) begin
			r.sample = x;
		end else begin
			v = x;
			v = v <<< IN_FRAC;
			for (int s = 0; s < n; s++) begin
				idx = ch * MAX_SECTIONS + s;
				w1 = tap1[idx];
				w2 = tap2[idx];
				acc = (v <<< FRAC_SHIFT) - coef_at(NUM_W'(den_cfg[s]), 0) * w1
					- coef_at(NUM_W'(den_cfg[s]), COEF_W) * w2;
				wn = to_word(acc);
				acc = coef_at(num_cfg[s], 0) * wn + coef_at(num_cfg[s], COEF_W) * w1
					+ coef_at(num_cfg[s], 2 * COEF_W) * w2;
				v = to_word(acc);
				tap2[idx] = w1[W_W-1:0];
				tap1[idx] = wn[W_W-1:0];
			end
			v = (v + 64'sd128) >>> IN_FRAC;
			if (v > SMP_HI) begin
				clip_seen = 1'b1;
				v = SMP_HI;
			end else if (v < SMP_LO) begin
				clip_seen = 1'b1;
				v = SMP_LO;
			end
			r.sample = v[S_W-1:0];
		end
		r.sat = clip_seen;
		return r;
	endfunction

	function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_SEC0_NUM: num_cfg[0] = data[NUM_W-1:0];
			REG_SEC0_DEN: den_cfg[0] = data[DEN_W-1:0];
			REG_SEC1_NUM: num_cfg[1] = data[NUM_W-1:0];
			REG_SEC1_DEN: den_cfg[1] = data[DEN_W-1:0];
			REG_NSEC:     nsec_cfg = data[NSEC_W-1:0];
			default: ;
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] wide_rand();
		return CFG_DATA_W'({$urandom, $urandom});
	endfunction

	// stable mode keeps the poles well inside the unit circle
	function automatic logic [COEF_W-1:0] pick_coef(input int mode, input bit feedback);
		logic [COEF_W-1:0] c;
		if (mode == 0) begin
			if (feedback)
				c = COEF_W'(int'($urandom_range(0, 65536)) - 32768);
			else
				c = COEF_W'(int'($urandom_range(0, 262144)) - 131072);
		end else if (mode == 1) begin
			c = COEF_W'($urandom);
		end else begin
			case ($urandom_range(0, 4))
				0: c = COEF_TOP;
				1: c = COEF_BOTTOM;
				2: c = COEF_ONE;
				3: c = COEF_LSB_N;
				default: c = '0;
			endcase
		end
		return c;
	endfunction

	function automatic logic signed [S_W-1:0] pick_sample();
		int pick;
		pick = $urandom_range(0, 19);
		if (pick < 14)
			return S_W'($urandom);
		else if (pick < 17)
			return S_W'(int'($urandom_range(0, 511)) - 256);
		else if (pick == 17)
			return S_MAX;
		else if (pick == 18)
			return S_MIN;
		else
			return $urandom_range(0, 1) ? S_W'(-1) : S_W'(0);
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch %s at result %0d: got %0d, want %0d",
			what, results_seen, got, want);
		errors++;
	endtask

	always @(posedge clk) begin : score_out
		filt_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (filtered_q.size() == 0) begin
				report_mismatch("unexpected result, chan", chan_out, -1);
			end else begin
				want = filtered_q.pop_front();
				if (chan_out !== want.chan)
					report_mismatch("chan_out", chan_out, want.chan);
				if (sample_out !== want.sample)
					report_mismatch("sample_out", sample_out, want.sample);
				if (saturated !== want.sat)
					report_mismatch("saturated", saturated, want.sat);
			end
			results_seen++;
		end
	end

	task automatic send_sample(input logic [CHAN_W-1:0] ch, input logic signed [S_W-1:0] x,
			input bit known, input logic signed [S_W-1:0] y, input bit y_sat);
		int gap;
		filt_t r;
		gap = 0;
		while (!no_gaps && $urandom_range(0, 99) < GAP_PCT)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		chan <= ch;
		sample_in <= x;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		r = biquad_predict(ch, x);
		if (known) begin
			r.sample = y;
			r.sat = y_sat;
		end
		filtered_q.push_back(r);
		samples_sent++;
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		apply_reg(idx, data);
		writes_done++;
		@(negedge clk);
	endtask

	// hold input off and let every pending sample come out before touching registers
	task automatic open_config();
		in_valid <= 1'b0;
		while (filtered_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic add_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		row_t r;
		r = '0;
		r.kind = ROW_WRITE;
		r.idx = idx;
		r.data = data;
		plan.push_back(r);
	endtask

	task automatic add_sample(input logic [CHAN_W-1:0] ch, input logic signed [S_W-1:0] x,
			input bit known, input logic signed [S_W-1:0] y, input bit y_sat);
		row_t r;
		r.kind = ROW_SAMPLE;
		r.idx = '0;
		r.data = '0;
		r.chan = ch;
		r.x = x;
		r.known = known;
		r.y = y;
		r.y_sat = y_sat;
		plan.push_back(r);
	endtask

	initial begin : stimulus
		bit cfg_open;
		int mode, nsec;
		logic [CFG_DATA_W-1:0] word;

		for (int i = 0; i < NUM_COEF_SETS; i++) begin
			num_cfg[i] = '0;
			den_cfg[i] = '0;
		end
		nsec_cfg = '0;
		for (int i = 0; i < DEPTH; i++) begin
			tap1[i] = '0;
			tap2[i] = '0;
		end

		// pass-through after reset
		add_sample(0, 0, 1, 0, 0);
		add_sample(7, S_MAX, 1, S_MAX, 0);
		add_sample(3, S_MIN, 1, S_MIN, 0);
		add_sample(5, -1, 1, -1, 0);
		// unity b0, one section
		add_write(REG_SEC0_NUM, {20'h0, 20'h0, COEF_ONE});
		add_write(REG_SEC0_DEN, '0);
		add_write(REG_NSEC, CFG_DATA_W'(1));
		add_sample(2, S_MAX, 1, S_MAX, 0);
		add_sample(2, S_MIN, 1, S_MIN, 0);
		add_sample(4, 12345, 1, 12345, 0);
		// near-4x gain clips the output
		add_write(REG_SEC0_NUM, {20'h0, 20'h0, COEF_TOP});
		add_sample(1, S_MAX, 1, S_MAX, 1);
		add_sample(1, S_MIN, 1, S_MIN, 1);
		// write to an unused index must change nothing
		add_write(REG_UNUSED, '1);
		add_sample(1, 0, 1, 0, 0);
		// extreme coefficients, section count above the maximum
		add_write(REG_SEC0_NUM, {COEF_BOTTOM, COEF_TOP, COEF_ONE});
		add_write(REG_SEC0_DEN, CFG_DATA_W'({COEF_TOP, COEF_BOTTOM}));
		add_write(REG_SEC1_NUM, '1);
		add_write(REG_SEC1_DEN, CFG_DATA_W'({COEF_BOTTOM, COEF_TOP}));
		add_write(REG_NSEC, CFG_DATA_W'(3));
		for (int i = 0; i < 4; i++)
			add_sample(6, S_MAX, 0, 0, 0);
		for (int i = 0; i < 4; i++)
			add_sample(6, S_MIN, 0, 0, 0);
		add_sample(1, S_MAX, 0, 0, 0);
		// zero sections: pass-through with delay words left alone
		add_write(REG_NSEC, CFG_DATA_W'(0));
		add_sample(6, S_MIN, 1, S_MIN, 0);
		add_sample(7, -4660, 1, -4660, 0);
		// moderate two-section filter on top of the state built above
		add_write(REG_SEC0_NUM, {20'hFC000, 20'h08000, 20'h10000});
		add_write(REG_SEC0_DEN, CFG_DATA_W'({20'h04000, 20'hF0000}));
		add_write(REG_SEC1_NUM, {20'h02000, 20'hFE000, COEF_ONE});
		add_write(REG_SEC1_DEN, CFG_DATA_W'({20'hFE000, 20'h01000}));
		add_write(REG_NSEC, CFG_DATA_W'(2));
		add_sample(6, 1000, 0, 0, 0);
		add_sample(6, -70000, 0, 0, 0);
		add_sample(3, S_MAX, 0, 0, 0);

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		cfg_open = 1'b0;
		for (int i = 0; i < plan.size(); i++) begin
			if (plan[i].kind == ROW_WRITE) begin
				if (!cfg_open) begin
					open_config();
					cfg_open = 1'b1;
				end
				write_reg(plan[i].idx, plan[i].data);
			end else begin
				if (cfg_open) begin
					cfg_valid <= 1'b0;
					cfg_open = 1'b0;
				end
				send_sample(plan[i].chan, plan[i].x, plan[i].known, plan[i].y, plan[i].y_sat);
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			mode = (p % 4 == 1) ? 1 : ((p % 4 == 3) ? 2 : 0);
			nsec = (p % 5 == 2) ? 0 : ((p % 5 == 4) ? 3 : $urandom_range(1, 2));
			no_gaps = (p == 5 || p == 6);
			open_config();
			write_reg(REG_SEC0_NUM, {pick_coef(mode, 0), pick_coef(mode, 0), pick_coef(mode, 0)});
			write_reg(REG_SEC0_DEN, {20'($urandom), pick_coef(mode, 1), pick_coef(mode, 1)});
			write_reg(REG_SEC1_NUM, {pick_coef(mode, 0), pick_coef(mode, 0), pick_coef(mode, 0)});
			write_reg(REG_SEC1_DEN, {20'($urandom), pick_coef(mode, 1), pick_coef(mode, 1)});
			if ($urandom_range(0, 1))
				write_reg(CFG_IDX_W'($urandom_range(REG_UNUSED, (1 << CFG_IDX_W) - 1)),
					wide_rand());
			word = wide_rand();
			word[NSEC_W-1:0] = NSEC_W'(nsec);
			write_reg(REG_NSEC, word);
			cfg_valid <= 1'b0;
			for (int k = 0; k < PHASE_ITEMS; k++)
				send_sample(CHAN_W'($urandom_range(0, CHANNELS - 1)), pick_sample(), 0, 0, 0);
		end

		no_gaps = 1'b0;
		in_valid <= 1'b0;
		while (filtered_q.size() != 0)
			@(negedge clk);
		repeat (TAIL) @(posedge clk);

		$display("run: %0d samples over %0d register writes, %0d results scored",
			samples_sent, writes_done, results_seen);
		$display("run: pass-through, one, two and over-range section counts, extreme and random taps");
		if (errors == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
